/* rtl/smcp_pkg.sv */
// Shared types and constants for the seam-carving minimum-path block.
// Used by smcp_cfg, smcp_ctrl, smcp_dp and seam_carving_min_path.
`timescale 1ns / 1ps

package smcp_pkg;

    // Fixed field widths of the channels
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int ENERGY_W   = 16;
    localparam int IDX_W      = 9;

    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [IDX_W-1:0]      idx_t;

    // Register indexes on the configuration port
    localparam cfg_idx_t REG_TOWARD_LOW   = cfg_idx_t'(0);
    localparam cfg_idx_t REG_LINE_LENGTH  = cfg_idx_t'(1);
    localparam cfg_idx_t REG_LINE_COUNT   = cfg_idx_t'(2);
    localparam cfg_idx_t REG_SEAM_PENALTY = cfg_idx_t'(3);

    // Register reset values
    localparam logic        TOWARD_LOW_RST  = 1'b0;
    localparam logic [9:0]  LINE_LENGTH_RST = 10'd512;
    localparam logic [9:0]  LINE_COUNT_RST  = 10'd512;
    localparam logic [15:0] PENALTY_RST     = 16'd8192;

    // Opcodes and status codes
    localparam logic OP_LOAD        = 1'b0;
    localparam logic OP_READ        = 1'b1;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_SEAM = 1'b1;

    // Energy value of a blocked border pixel
    localparam logic [ENERGY_W-1:0] BLOCKED_ENERGY = 16'hFFFF;

    typedef enum logic [1:0] {
        CH_STRAIGHT = 2'd0,
        CH_LOW      = 2'd1,
        CH_HIGH     = 2'd2
    } choice_t;

    typedef enum logic [1:0] {
        SHIFT_NONE = 2'd0,
        SHIFT_LOW  = 2'd1,
        SHIFT_HIGH = 2'd2
    } shift_t;

    // Neighbour in the previous line to fetch
    typedef enum logic [1:0] {
        NB_MID = 2'd0,
        NB_LO  = 2'd1,
        NB_HI  = 2'd2
    } nb_sel_t;

    typedef struct packed {
        logic                opcode;
        logic [ENERGY_W-1:0] energy;
        logic                seam_mark;
    } in_word_t;

    typedef struct packed {
        idx_t       line_index;
        idx_t       seam_position;
        logic [1:0] shift_dir;
        logic       status;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic        toward_low;
        logic [9:0]  line_length;
        logic [9:0]  line_count;
        logic [15:0] seam_penalty;
    } cfg_t;

    // Strobes from the controller to the datapath
    typedef struct packed {
        logic    take;        // latch accepted word, settle frame start
        logic    cost_rd;     // read previous-line cost
        nb_sel_t cost_sel;    // which neighbour to read
        logic    cap_mid;     // capture straight neighbour
        logic    cap_lo;      // capture lower neighbour
        logic    pick;        // choose least neighbour
        logic    add_energy;  // add pixel energy
        logic    add_pen;     // add seam penalty, apply first line and blocked cases
        logic    commit;      // write cost and choice, advance load position
        logic    ch_rd;       // read choice for the trace step
        logic    emit;        // load result word, advance trace
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;       // result register can take a word this cycle
        logic out_busy;       // result register holds an undelivered word
    } dp_status_t;

endpackage

/* rtl/smcp_cfg.sv */
// Configuration register file of the seam-carving block.
// Depends on smcp_pkg; drives register values and the frame restart strobe.
`timescale 1ns / 1ps

module smcp_cfg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  smcp_pkg::cfg_idx_t    cfg_index,
    input  smcp_pkg::cfg_data_t   cfg_data,
    output smcp_pkg::cfg_t        cfg,
    output logic                  frame_restart
);

    smcp_pkg::cfg_t cfg_reg;
    smcp_pkg::cfg_t cfg_next;
    logic           wr;

    // Always take writes
    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid;

    // Decode the write, mask each value to its register width
    always_comb begin
        cfg_next      = cfg_reg;
        frame_restart = 1'b0;
        if (wr) begin
            unique case (cfg_index)
                smcp_pkg::REG_TOWARD_LOW: begin
                    cfg_next.toward_low = cfg_data[0];
                end
                smcp_pkg::REG_LINE_LENGTH: begin
                    cfg_next.line_length = cfg_data[9:0];
                    frame_restart        = 1'b1;
                end
                smcp_pkg::REG_LINE_COUNT: begin
                    cfg_next.line_count = cfg_data[9:0];
                    frame_restart       = 1'b1;
                end
                smcp_pkg::REG_SEAM_PENALTY: begin
                    cfg_next.seam_penalty = cfg_data[15:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.toward_low   <= smcp_pkg::TOWARD_LOW_RST;
            cfg_reg.line_length  <= smcp_pkg::LINE_LENGTH_RST;
            cfg_reg.line_count   <= smcp_pkg::LINE_COUNT_RST;
            cfg_reg.seam_penalty <= smcp_pkg::PENALTY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/smcp_ctrl.sv */
// Controller of the seam-carving block: sequences each word through the datapath.
// Depends on smcp_pkg; talks to smcp_dp only through dp_cmd_t and dp_status_t.
`timescale 1ns / 1ps

module smcp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 opcode,
    input  smcp_pkg::dp_status_t status,
    output smcp_pkg::dp_cmd_t    cmd
);

    typedef enum logic [10:0] {
        ST_IDLE    = 11'b000_0000_0001,
        ST_LD_C    = 11'b000_0000_0010,
        ST_LD_L    = 11'b000_0000_0100,
        ST_LD_H    = 11'b000_0000_1000,
        ST_LD_MIN  = 11'b000_0001_0000,
        ST_LD_ADD  = 11'b000_0010_0000,
        ST_LD_PEN  = 11'b000_0100_0000,
        ST_LD_WR   = 11'b000_1000_0000,
        ST_RD_ADDR = 11'b001_0000_0000,
        ST_RD_MEM  = 11'b010_0000_0000,
        ST_RD_OUT  = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and datapath strobes
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.cost_sel = smcp_pkg::NB_MID;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = (opcode == smcp_pkg::OP_READ) ? ST_RD_ADDR : ST_LD_C;
                end
            end
            ST_LD_C: begin
                cmd.cost_rd  = 1'b1;
                cmd.cost_sel = smcp_pkg::NB_MID;
                state_next   = ST_LD_L;
            end
            ST_LD_L: begin
                cmd.cost_rd  = 1'b1;
                cmd.cost_sel = smcp_pkg::NB_LO;
                cmd.cap_mid  = 1'b1;
                state_next   = ST_LD_H;
            end
            ST_LD_H: begin
                cmd.cost_rd  = 1'b1;
                cmd.cost_sel = smcp_pkg::NB_HI;
                cmd.cap_lo   = 1'b1;
                state_next   = ST_LD_MIN;
            end
            ST_LD_MIN: begin
                cmd.pick   = 1'b1;
                state_next = ST_LD_ADD;
            end
            ST_LD_ADD: begin
                cmd.add_energy = 1'b1;
                state_next     = ST_LD_PEN;
            end
            ST_LD_PEN: begin
                cmd.add_pen = 1'b1;
                state_next  = ST_LD_WR;
            end
            ST_LD_WR: begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RD_ADDR: begin
                // choice address settles in the datapath
                state_next = ST_RD_MEM;
            end
            ST_RD_MEM: begin
                cmd.ch_rd  = 1'b1;
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                // hold until the result register frees up
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/smcp_dp.sv */
// Datapath of the seam-carving block: line cost and choice memories, frame and
// trace counters, cost arithmetic and the result register. Depends on smcp_pkg.
`timescale 1ns / 1ps

module smcp_dp #(
    parameter int MAX_LINE_LEN = 512,
    parameter int MAX_LINES    = 512,
    parameter int COST_BITS    = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  smcp_pkg::in_word_t   s_data,
    input  smcp_pkg::cfg_t       cfg,
    input  logic                 frame_restart,
    input  smcp_pkg::dp_cmd_t    cmd,
    output smcp_pkg::dp_status_t status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output smcp_pkg::out_word_t  m_data
);

    localparam int POS_W    = $clog2(MAX_LINE_LEN);
    localparam int LEN_W    = $clog2(MAX_LINE_LEN + 1);
    localparam int LINE_W   = $clog2(MAX_LINES);
    localparam int CNT_W    = $clog2(MAX_LINES + 1);
    localparam int CH_DEPTH = MAX_LINES * MAX_LINE_LEN;
    localparam int CH_AW    = $clog2(CH_DEPTH);

    localparam logic [COST_BITS-1:0] COST_MAX = '1;

    function automatic logic [COST_BITS-1:0] sat_add(
        input logic [COST_BITS-1:0] a,
        input logic [COST_BITS-1:0] b
    );
        logic [COST_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_BITS] ? COST_MAX : s[COST_BITS-1:0];
    endfunction

    // Memories: costs of two lines (ping-pong on line parity), choice per pixel
    logic [COST_BITS-1:0] cost_mem [2][MAX_LINE_LEN];
    logic [1:0]           choice_mem [CH_DEPTH];

    // Frame and trace state
    logic [LINE_W-1:0]    load_line_reg, load_line_next;
    logic [POS_W-1:0]     load_pos_reg, load_pos_next;
    logic [COST_BITS-1:0] best_cost_reg, best_cost_next;
    logic [POS_W-1:0]     trace_pos_reg, trace_pos_next;
    logic [LINE_W-1:0]    trace_line_reg, trace_line_next;
    logic                 seam_ready_reg, seam_ready_next;
    logic                 m_valid_reg, m_valid_next;

    // Per-word working registers
    logic [LINE_W-1:0]          cur_line_reg;
    logic [POS_W-1:0]           cur_pos_reg;
    logic [smcp_pkg::ENERGY_W-1:0] energy_reg;
    logic                       mark_reg;
    logic                       op_read_reg;
    logic [POS_W-1:0]           rd_pos_reg;
    logic                       no_seam_reg;
    logic [COST_BITS-1:0]       cost_rd_data_reg;
    logic [COST_BITS-1:0]       mid_reg;
    logic [COST_BITS-1:0]       lo_reg;
    logic [COST_BITS-1:0]       mn_reg;
    smcp_pkg::choice_t          pick_reg;
    logic [COST_BITS-1:0]       sum_reg;
    logic [COST_BITS-1:0]       cost_reg;
    logic [CH_AW-1:0]           ch_addr_reg;
    logic [1:0]                 ch_rd_data_reg;
    smcp_pkg::out_word_t        m_data_reg;

    logic [LEN_W-1:0]     eff_len;
    logic [CNT_W-1:0]     eff_cnt;
    logic                 restart_now;
    logic [LEN_W-1:0]     cur_pos_inc;
    logic                 last_line;
    logic [POS_W-1:0]     cost_rd_addr;
    logic [COST_BITS-1:0] mn_c;
    smcp_pkg::choice_t    pick_c;
    logic [COST_BITS-1:0] cost_c;
    logic [LEN_W-1:0]     rd_pos_inc;
    logic [POS_W-1:0]     step_pos;
    logic [LINE_W-1:0]    ch_line_sel;
    logic [POS_W-1:0]     ch_pos_sel;
    smcp_pkg::out_word_t  out_c;

    // Clamp length and count into 1..maximum
    always_comb begin
        priority if (cfg.line_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(cfg.line_length) > 32'(MAX_LINE_LEN)) begin
            eff_len = LEN_W'(MAX_LINE_LEN);
        end else begin
            eff_len = LEN_W'(cfg.line_length);
        end
        priority if (cfg.line_count == '0) begin
            eff_cnt = CNT_W'(1);
        end else if (32'(cfg.line_count) > 32'(MAX_LINES)) begin
            eff_cnt = CNT_W'(MAX_LINES);
        end else begin
            eff_cnt = CNT_W'(cfg.line_count);
        end
    end

    // A load restarts the frame after a ready seam or past the frame edge
    assign restart_now = seam_ready_reg
                       || (CNT_W'(load_line_reg) >= eff_cnt)
                       || (LEN_W'(load_pos_reg) >= eff_len);

    assign cur_pos_inc = LEN_W'(cur_pos_reg) + LEN_W'(1);
    assign last_line   = (CNT_W'(cur_line_reg) + CNT_W'(1)) == eff_cnt;

    // Neighbour address in the previous line
    always_comb begin
        unique case (cmd.cost_sel)
            smcp_pkg::NB_MID: cost_rd_addr = cur_pos_reg;
            smcp_pkg::NB_LO:  cost_rd_addr = cur_pos_reg - POS_W'(1);
            smcp_pkg::NB_HI:  cost_rd_addr = cur_pos_reg + POS_W'(1);
            default:          cost_rd_addr = cur_pos_reg;
        endcase
    end

    // Least neighbour: straight first, then lower, then higher
    always_comb begin
        mn_c   = mid_reg;
        pick_c = smcp_pkg::CH_STRAIGHT;
        if (cur_pos_reg != '0 && lo_reg < mn_c) begin
            mn_c   = lo_reg;
            pick_c = smcp_pkg::CH_LOW;
        end
        if (cur_pos_inc < eff_len && cost_rd_data_reg < mn_c) begin
            mn_c   = cost_rd_data_reg;
            pick_c = smcp_pkg::CH_HIGH;
        end
        if (cur_line_reg == '0) begin
            pick_c = smcp_pkg::CH_STRAIGHT;
        end
    end

    // Penalty, first line and blocked pixel
    always_comb begin
        priority if (energy_reg == smcp_pkg::BLOCKED_ENERGY) begin
            cost_c = COST_MAX;
        end else if (cur_line_reg == '0) begin
            cost_c = COST_BITS'(energy_reg);
        end else if (mark_reg) begin
            cost_c = sat_add(sum_reg, COST_BITS'(cfg.seam_penalty));
        end else begin
            cost_c = sum_reg;
        end
    end

    // Trace step and result word
    assign rd_pos_inc = LEN_W'(rd_pos_reg) + LEN_W'(1);

    always_comb begin
        priority if (ch_rd_data_reg == smcp_pkg::CH_LOW && rd_pos_reg != '0) begin
            step_pos = rd_pos_reg - POS_W'(1);
        end else if (ch_rd_data_reg == smcp_pkg::CH_HIGH && rd_pos_inc < eff_len) begin
            step_pos = rd_pos_reg + POS_W'(1);
        end else begin
            step_pos = rd_pos_reg;
        end
    end

    always_comb begin
        out_c = '0;
        if (no_seam_reg) begin
            out_c.status = smcp_pkg::STATUS_NO_SEAM;
        end else begin
            out_c.status        = smcp_pkg::STATUS_OK;
            out_c.line_index    = smcp_pkg::idx_t'(trace_line_reg);
            out_c.seam_position = smcp_pkg::idx_t'(rd_pos_reg);
            out_c.last          = (trace_line_reg == '0);
            priority if (cfg.toward_low && rd_pos_reg != '0) begin
                out_c.shift_dir = smcp_pkg::SHIFT_LOW;
            end else if (rd_pos_inc < eff_len) begin
                out_c.shift_dir = smcp_pkg::SHIFT_HIGH;
            end else begin
                out_c.shift_dir = smcp_pkg::SHIFT_NONE;
            end
        end
    end

    // Frame, trace and result-valid control
    always_comb begin
        load_line_next  = load_line_reg;
        load_pos_next   = load_pos_reg;
        best_cost_next  = best_cost_reg;
        trace_pos_next  = trace_pos_reg;
        trace_line_next = trace_line_reg;
        seam_ready_next = seam_ready_reg;

        priority if (frame_restart) begin
            load_line_next  = '0;
            load_pos_next   = '0;
            seam_ready_next = 1'b0;
            best_cost_next  = COST_MAX;
        end else if (cmd.take && s_data.opcode == smcp_pkg::OP_LOAD && restart_now) begin
            seam_ready_next = 1'b0;
            best_cost_next  = COST_MAX;
        end

        if (cmd.commit) begin
            // track the cheapest end point, ties to the lowest position
            if (last_line && (cur_pos_reg == '0 || cost_reg < best_cost_reg)) begin
                best_cost_next = cost_reg;
                trace_pos_next = cur_pos_reg;
            end
            if (cur_pos_inc < eff_len) begin
                load_pos_next  = POS_W'(cur_pos_inc);
                load_line_next = cur_line_reg;
            end else begin
                load_pos_next = '0;
                if (!last_line) begin
                    load_line_next = cur_line_reg + LINE_W'(1);
                end else begin
                    load_line_next  = '0;
                    trace_line_next = cur_line_reg;
                    seam_ready_next = 1'b1;
                end
            end
        end

        if (cmd.emit && !no_seam_reg) begin
            if (trace_line_reg == '0 || 32'(trace_line_reg) >= 32'(MAX_LINES)) begin
                seam_ready_next = 1'b0;
            end else begin
                trace_pos_next  = step_pos;
                trace_line_next = trace_line_reg - LINE_W'(1);
            end
        end

        priority if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_line_reg  <= '0;
            load_pos_reg   <= '0;
            best_cost_reg  <= COST_MAX;
            trace_pos_reg  <= '0;
            trace_line_reg <= '0;
            seam_ready_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            load_line_reg  <= load_line_next;
            load_pos_reg   <= load_pos_next;
            best_cost_reg  <= best_cost_next;
            trace_pos_reg  <= trace_pos_next;
            trace_line_reg <= trace_line_next;
            seam_ready_reg <= seam_ready_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Latch the accepted word and its starting position
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            energy_reg   <= s_data.energy;
            mark_reg     <= s_data.seam_mark;
            op_read_reg  <= s_data.opcode;
            cur_line_reg <= restart_now ? '0 : load_line_reg;
            cur_pos_reg  <= restart_now ? '0 : load_pos_reg;
            rd_pos_reg   <= (LEN_W'(trace_pos_reg) < eff_len) ? trace_pos_reg
                                                             : POS_W'(eff_len - LEN_W'(1));
            no_seam_reg  <= !seam_ready_reg;
        end
    end

    // Arithmetic stages
    always_ff @(posedge aclk) begin
        if (cmd.cap_mid) begin
            mid_reg <= cost_rd_data_reg;
        end
        if (cmd.cap_lo) begin
            lo_reg <= cost_rd_data_reg;
        end
        if (cmd.pick) begin
            mn_reg   <= mn_c;
            pick_reg <= pick_c;
        end
        if (cmd.add_energy) begin
            sum_reg <= sat_add(mn_reg, COST_BITS'(energy_reg));
        end
        if (cmd.add_pen) begin
            cost_reg <= cost_c;
        end
        if (cmd.emit) begin
            m_data_reg <= out_c;
        end
    end

    // Line cost memory: write current line, read previous line
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            cost_mem[cur_line_reg[0]][cur_pos_reg] <= cost_reg;
        end
        if (cmd.cost_rd) begin
            cost_rd_data_reg <= cost_mem[!cur_line_reg[0]][cost_rd_addr];
        end
    end

    // Choice address: trace point on reads, load point otherwise
    assign ch_line_sel = op_read_reg ? trace_line_reg : cur_line_reg;
    assign ch_pos_sel  = op_read_reg ? rd_pos_reg : cur_pos_reg;

    always_ff @(posedge aclk) begin
        ch_addr_reg <= CH_AW'(ch_line_sel) * CH_AW'(MAX_LINE_LEN) + CH_AW'(ch_pos_sel);
    end

    // Choice memory
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            choice_mem[ch_addr_reg] <= pick_reg;
        end
        if (cmd.ch_rd) begin
            ch_rd_data_reg <= choice_mem[ch_addr_reg];
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign status.out_busy = m_valid_reg;
    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;

endmodule

/* rtl/seam_carving_min_path.sv */
// Top level of the seam-carving minimum-path block.
// Depends on smcp_pkg, smcp_cfg, smcp_ctrl and smcp_dp.
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Word
// s_       in         s_valid / s_ready      smcp_pkg::in_word_t (opcode, energy, seam_mark)
// m_       out        m_valid / m_ready      smcp_pkg::out_word_t (point, shift, status, last)
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load word occupies the block for three fetches of previous-line costs
// through the single read port of the line cost memory, then min, two saturating adds
// and the write-back. A read word sets up the choice address, reads the choice memory
// and emits, held while m_ready is low with an earlier result in the output register.
// Reset is synchronous on aresetn; no clearing pass, memories hold unknown data
// until written. cfg_ready is always high.

module seam_carving_min_path #(
    parameter int MAX_LINE_LEN = 512,
    parameter int MAX_LINES    = 512,
    parameter int COST_BITS    = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  smcp_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output smcp_pkg::out_word_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  smcp_pkg::cfg_idx_t  cfg_index,
    input  smcp_pkg::cfg_data_t cfg_data
);

    smcp_pkg::cfg_t       cfg;
    logic                 frame_restart;
    smcp_pkg::dp_cmd_t    cmd;
    smcp_pkg::dp_status_t status;

    smcp_cfg u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cfg           (cfg),
        .frame_restart (frame_restart)
    );

    smcp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .opcode  (s_data.opcode),
        .status  (status),
        .cmd     (cmd)
    );

    smcp_dp #(
        .MAX_LINE_LEN (MAX_LINE_LEN),
        .MAX_LINES    (MAX_LINES),
        .COST_BITS    (COST_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_data        (s_data),
        .cfg           (cfg),
        .frame_restart (frame_restart),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

`ifndef SYNTHESIS
    // Never overwrite a result word that has not been taken
    a_emit_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!status.out_busy || m_ready))
        else $error("result word overwritten before delivery");

    // The block is busy in the cycle after it accepts a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted on consecutive cycles");

    // A result appears only from an emit step of a read word
    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.emit))
        else $error("result word without a read step");

    // At most one of take, pick, add_energy, add_pen, commit, ch_rd and emit is active at a time
    a_single_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.take, cmd.pick, cmd.add_energy, cmd.add_pen,
                  cmd.commit, cmd.ch_rd, cmd.emit}))
        else $error("overlapping datapath steps");
`endif

endmodule

/* tb/tb_seam_carving_min_path.sv */
// Self-checking testbench for seam_carving_min_path.
// Drives pixel loads and seam reads over valid/ready, predicts every result word
// from a behavioural copy of the seam recurrence. Depends on smcp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_seam_carving_min_path;

    localparam int LEN_MAX      = 512;
    localparam int LINES_MAX    = 512;
    localparam int COST_W       = 32;
    localparam int SETTLE       = 16;
    localparam int CHOKE_CYCLES = 300;
    localparam int RANDOM_ITEMS = 220;
    localparam int RUN_LIMIT_NS = 1_000_000;

    localparam logic [COST_W-1:0] COST_SAT = '1;

    // Indexes outside the register list, expected to be ignored
    localparam smcp_pkg::cfg_idx_t REG_IDX_SPARE = smcp_pkg::cfg_idx_t'(4);
    localparam smcp_pkg::cfg_idx_t REG_IDX_TOP   = smcp_pkg::cfg_idx_t'(255);

    typedef struct packed {
        smcp_pkg::cfg_idx_t  idx;
        smcp_pkg::cfg_data_t val;
    } reg_write_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    smcp_pkg::in_word_t  s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    smcp_pkg::out_word_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    smcp_pkg::cfg_idx_t  cfg_index = '0;
    smcp_pkg::cfg_data_t cfg_data  = '0;

    // Stimulus queues and pacing controls
    smcp_pkg::in_word_t  word_q[$];
    reg_write_t          reg_q[$];
    smcp_pkg::out_word_t point_q[$];
    bit                  idle_on    = 1'b1;
    bit                  choke_arm  = 1'b0;
    bit                  choke_seen = 1'b0;
    int                  gap_left   = 0;
    int                  hold_left  = 0;
    int                  err_count  = 0;
    int                  queued     = 0;

    // Predicted block state
    bit                 cfg_toward_low = smcp_pkg::TOWARD_LOW_RST;
    bit [9:0]           cfg_line_len   = smcp_pkg::LINE_LENGTH_RST;
    bit [9:0]           cfg_line_cnt   = smcp_pkg::LINE_COUNT_RST;
    bit [15:0]          cfg_penalty    = smcp_pkg::PENALTY_RST;
    bit [COST_W-1:0]    prev_cost [LEN_MAX];
    bit [COST_W-1:0]    cur_cost  [LEN_MAX];
    smcp_pkg::choice_t  choice_mem [LINES_MAX*LEN_MAX];
    int                 ld_line = 0;
    int                 ld_pos  = 0;
    int                 tr_line = 0;
    int                 tr_pos  = 0;
    bit [COST_W-1:0]    best    = COST_SAT;
    bit                 seam_ok = 1'b0;

    seam_carving_min_path #(
        .MAX_LINE_LEN(LEN_MAX),
        .MAX_LINES   (LINES_MAX),
        .COST_BITS   (COST_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int used_len();
        if (cfg_line_len == 0) return 1;
        return (cfg_line_len > LEN_MAX) ? LEN_MAX : int'(cfg_line_len);
    endfunction

    function automatic int used_cnt();
        if (cfg_line_cnt == 0) return 1;
        return (cfg_line_cnt > LINES_MAX) ? LINES_MAX : int'(cfg_line_cnt);
    endfunction

    function automatic bit [COST_W-1:0] sat_sum(bit [COST_W-1:0] a, bit [COST_W-1:0] b);
        bit [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? COST_SAT : s[COST_W-1:0];
    endfunction

    function automatic void frame_restart();
        ld_line = 0;
        ld_pos  = 0;
        seam_ok = 1'b0;
        best    = COST_SAT;
    endfunction

    function automatic void apply_reg(smcp_pkg::cfg_idx_t idx, smcp_pkg::cfg_data_t val);
        case (idx)
            smcp_pkg::REG_TOWARD_LOW:   cfg_toward_low = val[0];
            smcp_pkg::REG_LINE_LENGTH: begin
                cfg_line_len = val[9:0];
                frame_restart();
            end
            smcp_pkg::REG_LINE_COUNT: begin
                cfg_line_cnt = val[9:0];
                frame_restart();
            end
            smcp_pkg::REG_SEAM_PENALTY: cfg_penalty = val;
            default: ;
        endcase
    endfunction

    // Run one pixel through the cost recurrence and latch the end point
    function automatic void seam_load_pixel(logic [smcp_pkg::ENERGY_W-1:0] energy, logic mark);
        int len, cnt, ln, ps;
        smcp_pkg::choice_t pick;
        bit [COST_W-1:0] mn, c;
        len  = used_len();
        cnt  = used_cnt();
        pick = smcp_pkg::CH_STRAIGHT;
        if (seam_ok) frame_restart();
        if (ld_line >= cnt || ld_pos >= len) frame_restart();
        ln = ld_line;
        ps = ld_pos;
        if (ln == 0) begin
            c = COST_W'(energy);
        end else begin
            mn = prev_cost[ps];
            if (ps > 0 && prev_cost[ps-1] < mn) begin
                mn   = prev_cost[ps-1];
                pick = smcp_pkg::CH_LOW;
            end
            if (ps + 1 < len && prev_cost[ps+1] < mn) begin
                mn   = prev_cost[ps+1];
                pick = smcp_pkg::CH_HIGH;
            end
            c = sat_sum(mn, COST_W'(energy));
            if (mark) c = sat_sum(c, COST_W'(cfg_penalty));
        end
        if (energy == smcp_pkg::BLOCKED_ENERGY) c = COST_SAT;
        cur_cost[ps] = c;
        choice_mem[ln*LEN_MAX + ps] = pick;
        if (ln + 1 == cnt && (ps == 0 || c < best)) begin
            best   = c;
            tr_pos = ps;
        end
        if (ps + 1 < len) begin
            ld_pos = ps + 1;
        end else begin
            for (int i = 0; i < len; i++) prev_cost[i] = cur_cost[i];
            ld_pos = 0;
            if (ln + 1 < cnt) begin
                ld_line = ln + 1;
            end else begin
                ld_line = 0;
                tr_line = ln;
                seam_ok = 1'b1;
            end
        end
    endfunction

    // Produce the next seam point and step the trace back one line
    function automatic smcp_pkg::out_word_t seam_read_point();
        smcp_pkg::out_word_t w;
        int len, ps;
        smcp_pkg::choice_t c;
        w = '0;
        if (!seam_ok) begin
            w.status = smcp_pkg::STATUS_NO_SEAM;
            return w;
        end
        len = used_len();
        ps  = (tr_pos < len) ? tr_pos : len - 1;
        w.line_index    = smcp_pkg::idx_t'(tr_line);
        w.seam_position = smcp_pkg::idx_t'(ps);
        if (cfg_toward_low && ps > 0)
            w.shift_dir = smcp_pkg::SHIFT_LOW;
        else if (ps + 1 < len)
            w.shift_dir = smcp_pkg::SHIFT_HIGH;
        else
            w.shift_dir = smcp_pkg::SHIFT_NONE;
        w.status = smcp_pkg::STATUS_OK;
        w.last   = (tr_line == 0);
        if (tr_line == 0 || tr_line >= LINES_MAX) begin
            seam_ok = 1'b0;
        end else begin
            c = choice_mem[tr_line*LEN_MAX + ps];
            if (c == smcp_pkg::CH_LOW && ps > 0)
                ps--;
            else if (c == smcp_pkg::CH_HIGH && ps + 1 < len)
                ps++;
            tr_pos = ps;
            tr_line--;
        end
        return w;
    endfunction

    // ------------------------------------------------------------ drivers

    // Input channel: hold the word until taken, insert random gaps between words
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            s_data   <= '0;
            gap_left <= 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (word_q.size() != 0) begin
                s_data  <= word_q.pop_front();
                s_valid <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 19);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Configuration channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end else if (!cfg_valid || cfg_ready) begin
            if (reg_q.size() != 0) begin
                {cfg_index, cfg_data} <= reg_q.pop_front();
                cfg_valid <= 1'b1;
            end else begin
                cfg_valid <= 1'b0;
            end
        end
    end

    // Result channel: random stall bursts, plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            hold_left  <= 0;
            choke_seen <= 1'b0;
        end else if (choke_arm != choke_seen) begin
            choke_seen <= choke_arm;
            hold_left  <= CHOKE_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            hold_left <= $urandom_range(0, 18);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------ monitor

    task automatic flag_error(string msg);
        err_count++;
        $display("ERROR %0t ns: %s", $time, msg);
    endtask

    // Check delivered points first, then fold accepted words into the prediction
    always @(posedge aclk) begin
        smcp_pkg::out_word_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (point_q.size() == 0) begin
                    flag_error($sformatf("result word %h with nothing pending", m_data));
                end else begin
                    want = point_q.pop_front();
                    if (m_data.line_index !== want.line_index)
                        flag_error($sformatf("line_index got %0d want %0d",
                                             m_data.line_index, want.line_index));
                    if (m_data.seam_position !== want.seam_position)
                        flag_error($sformatf("seam_position got %0d want %0d",
                                             m_data.seam_position, want.seam_position));
                    if (m_data.shift_dir !== want.shift_dir)
                        flag_error($sformatf("shift_dir got %0d want %0d",
                                             m_data.shift_dir, want.shift_dir));
                    if (m_data.status !== want.status)
                        flag_error($sformatf("status got %0d want %0d",
                                             m_data.status, want.status));
                    if (m_data.last !== want.last)
                        flag_error($sformatf("last got %0d want %0d", m_data.last, want.last));
                end
            end
            if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                if (s_data.opcode == smcp_pkg::OP_LOAD) begin
                    seam_load_pixel(s_data.energy, s_data.seam_mark);
                end else begin
                    want    = seam_read_point();
                    point_q = {point_q, want};
                end
            end
        end
    end

    // ------------------------------------------------------------ stimulus

    task automatic queue_load(logic [smcp_pkg::ENERGY_W-1:0] energy, logic mark);
        smcp_pkg::in_word_t w;
        w.opcode    = smcp_pkg::OP_LOAD;
        w.energy    = energy;
        w.seam_mark = mark;
        word_q = {word_q, w};
        queued++;
    endtask

    task automatic queue_read();
        smcp_pkg::in_word_t w;
        w.opcode    = smcp_pkg::OP_READ;
        w.energy    = 16'($urandom());
        w.seam_mark = 1'($urandom());
        word_q = {word_q, w};
        queued++;
    endtask

    // Bias energies toward ties, the blocked value and the top of the range
    function automatic logic [smcp_pkg::ENERGY_W-1:0] pick_energy();
        case ($urandom_range(0, 9))
            0:       return smcp_pkg::BLOCKED_ENERGY;
            1:       return '0;
            2:       return smcp_pkg::BLOCKED_ENERGY - 16'd1;
            3, 4, 5: return smcp_pkg::ENERGY_W'($urandom_range(0, 3));
            default: return smcp_pkg::ENERGY_W'($urandom());
        endcase
    endfunction

    task automatic queue_frame();
        repeat (used_len() * used_cnt()) queue_load(pick_energy(), 1'($urandom()));
    endtask

    task automatic queue_noise(int n);
        repeat (n) begin
            if ($urandom_range(0, 1)) queue_read();
            else queue_load(pick_energy(), 1'($urandom()));
        end
    endtask

    task automatic write_reg(smcp_pkg::cfg_idx_t idx, int val);
        reg_write_t w;
        w.idx = idx;
        w.val = smcp_pkg::cfg_data_t'(val);
        reg_q = {reg_q, w};
    endtask

    // Hold until every word is in and every point is out, then let the block settle
    task automatic wait_idle();
        do @(negedge aclk); while (word_q.size() != 0 || s_valid || point_q.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic flush_regs();
        do @(negedge aclk); while (reg_q.size() != 0 || cfg_valid);
    endtask

    function automatic int pick_size(int hi);
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 'hFC00 | $urandom_range(1, hi);
            default: return $urandom_range(1, hi);
        endcase
    endfunction

    function automatic int pick_penalty();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 'hFFFF;
            2:       return int'(smcp_pkg::PENALTY_RST);
            default: return $urandom_range(0, 'hFFFF);
        endcase
    endfunction

    initial begin
        int start;
        int k;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reads with nothing loaded, and a stray load under the reset sizes
        queue_read();
        queue_load(16'h0000, 1'b1);
        queue_read();
        wait_idle();

        // 3x3 frame: blocked border, ties and the penalty on marked pixels
        write_reg(smcp_pkg::REG_TOWARD_LOW, 1);
        write_reg(smcp_pkg::REG_LINE_LENGTH, 3);
        write_reg(smcp_pkg::REG_LINE_COUNT, 3);
        write_reg(smcp_pkg::REG_SEAM_PENALTY, 'hFFFF);
        flush_regs();
        queue_load(smcp_pkg::BLOCKED_ENERGY, 1'b1);
        queue_load(16'h0000, 1'b0);
        queue_load(smcp_pkg::BLOCKED_ENERGY - 16'd1, 1'b1);
        queue_load(16'h0001, 1'b1);
        queue_load(16'h0001, 1'b0);
        queue_load(16'h0001, 1'b1);
        queue_load(16'h0000, 1'b1);
        queue_load(smcp_pkg::BLOCKED_ENERGY, 1'b0);
        queue_load(16'h0000, 1'b0);
        repeat (4) queue_read();
        wait_idle();

        // 2x2 all-equal frame, trace cut short by a fresh load
        write_reg(smcp_pkg::REG_TOWARD_LOW, 0);
        write_reg(smcp_pkg::REG_LINE_LENGTH, 2);
        write_reg(smcp_pkg::REG_LINE_COUNT, 2);
        flush_regs();
        repeat (4) queue_load(16'h0005, 1'b0);
        queue_read();
        queue_load(16'h0005, 1'b0);
        queue_read();
        wait_idle();

        // Wide line, single line (count masked down to 1)
        write_reg(smcp_pkg::REG_LINE_LENGTH, 64);
        write_reg(smcp_pkg::REG_LINE_COUNT, 'hFC01);
        write_reg(REG_IDX_TOP, 'hFFFF);
        flush_regs();
        idle_on = 1'b0;
        queue_frame();
        repeat (2) queue_read();
        wait_idle();

        // Zero length and oversize count clamp; partial frame only
        write_reg(smcp_pkg::REG_LINE_LENGTH, 0);
        write_reg(smcp_pkg::REG_LINE_COUNT, 'h3FF);
        write_reg(REG_IDX_SPARE, 1);
        flush_regs();
        idle_on = 1'b1;
        queue_noise(20);
        wait_idle();

        // Long receiver hold-off while reads keep coming
        write_reg(smcp_pkg::REG_LINE_LENGTH, 2);
        write_reg(smcp_pkg::REG_LINE_COUNT, 3);
        flush_regs();
        idle_on = 1'b0;
        choke_arm = ~choke_arm;
        queue_frame();
        repeat (40) queue_read();
        wait_idle();

        // Random phases: mostly whole frames and traces, some broken and noisy
        start = queued;
        while (queued - start < RANDOM_ITEMS) begin
            write_reg(smcp_pkg::REG_LINE_LENGTH, pick_size(8));
            write_reg(smcp_pkg::REG_LINE_COUNT, pick_size(6));
            write_reg(smcp_pkg::REG_TOWARD_LOW, $urandom_range(0, 3));
            write_reg(smcp_pkg::REG_SEAM_PENALTY, pick_penalty());
            if ($urandom_range(0, 5) == 0) write_reg(REG_IDX_SPARE, $urandom());
            flush_regs();
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 9))
                    0, 1: queue_noise($urandom_range(1, 10));
                    2: begin
                        queue_frame();
                        k = $urandom_range(0, used_cnt());
                        repeat (k) queue_read();
                        repeat ($urandom_range(1, used_len())) queue_load(pick_energy(), 1'b0);
                        queue_read();
                    end
                    default: begin
                        queue_frame();
                        repeat (used_cnt() + $urandom_range(0, 1)) queue_read();
                    end
                endcase
            end
            wait_idle();
        end

        // Closing stretch without idling on either side
        idle_on = 1'b0;
        write_reg(smcp_pkg::REG_LINE_LENGTH, 4);
        write_reg(smcp_pkg::REG_LINE_COUNT, 3);
        write_reg(smcp_pkg::REG_TOWARD_LOW, 1);
        flush_regs();
        repeat (2) begin
            queue_frame();
            repeat (4) queue_read();
        end
        wait_idle();

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
